FILE: rtl/fpw_pkg.sv
package fpw_pkg;

  localparam int VADDR_BITS  = 48;
  localparam int PA_WIDTH    = 52;
  localparam int ENTRY_WIDTH = 64;
  localparam int PAGE_SHIFT  = 12;
  localparam int HUGE_SHIFT  = 21;
  localparam int IDX_BITS    = 9;
  localparam int PAGE_BITS   = PA_WIDTH - PAGE_SHIFT;
  localparam int BIT_PRESENT = 0;
  localparam int BIT_HUGE    = 7;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_STRAY = 2'd2
  } kind_t;

  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  // classified item handed from front to back
  typedef struct packed {
    logic                  is_req;
    logic [VADDR_BITS-1:0] vaddr;
    logic                  present;
    logic                  huge;
    logic [PAGE_BITS-1:0]  page;
  } item_t;

  typedef struct packed {
    kind_t               kind;
    logic [PA_WIDTH-1:0] read_addr;
    logic [PA_WIDTH-1:0] phys_addr;
    logic                fault;
    logic [1:0]          fault_level;
    logic                huge_page;
  } result_t;

endpackage

FILE: rtl/fpw_fifo.sv
module fpw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] LIMIT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == LIMIT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/fpw_front.sv
module fpw_front import fpw_pkg::*; #(
  parameter int PADDR_BITS = 52
) (
  input  logic                   mode,
  input  logic [VADDR_BITS-1:0]  virt_addr,
  input  logic [ENTRY_WIDTH-1:0] entry_data,
  output item_t                  item
);

  localparam logic [PA_WIDTH-1:0] PA_MASK = PA_WIDTH'({PADDR_BITS{1'b1}});

  logic [PA_WIDTH-1:0] entry_pa;

  // drop entry flag bits and bits beyond the physical address width
  assign entry_pa = entry_data[PA_WIDTH-1:0] & PA_MASK;

  always_comb begin
    item.is_req  = !mode;
    item.vaddr   = virt_addr;
    item.present = entry_data[BIT_PRESENT];
    item.huge    = entry_data[BIT_HUGE];
    item.page    = entry_pa[PA_WIDTH-1:PAGE_SHIFT];
  end

endmodule

FILE: rtl/fpw_back.sv
module fpw_back import fpw_pkg::*; #(
  parameter int PADDR_BITS = 52
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [PA_WIDTH-1:0] cfg_data,
  input  logic                item_valid,
  input  item_t               item,
  input  logic                res_full,
  output logic                step,
  output result_t             res
);

  localparam logic [PA_WIDTH-1:0] PA_MASK = PA_WIDTH'({PADDR_BITS{1'b1}});

  logic [PA_WIDTH-1:0]   root_table_base;
  logic                  walk_busy;
  logic [1:0]            walk_level;
  logic [VADDR_BITS-1:0] held_vaddr;
  logic                  walk_busy_next;
  logic [1:0]            walk_level_next;
  logic [VADDR_BITS-1:0] held_vaddr_next;
  logic [PA_WIDTH-1:0]   root_pa;

  function automatic logic [IDX_BITS-1:0] level_index(input logic [VADDR_BITS-1:0] va,
                                                      input logic [1:0] lvl);
    logic [IDX_BITS-1:0] idx;
    unique case (lvl)
      LVL_PML4: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      default:  idx = va[20:12];
    endcase
    return idx;
  endfunction

  assign step    = item_valid && !res_full;
  assign root_pa = root_table_base & PA_MASK;

  always_comb begin
    walk_busy_next  = walk_busy;
    walk_level_next = walk_level;
    held_vaddr_next = held_vaddr;
    res             = '0;
    res.kind        = KIND_READ;
    priority if (item.is_req) begin
      // restart at PML4 whatever walk was in flight
      held_vaddr_next = item.vaddr;
      walk_busy_next  = 1'b1;
      walk_level_next = LVL_PML4;
      res.read_addr   = {root_pa[PA_WIDTH-1:PAGE_SHIFT],
                         level_index(item.vaddr, LVL_PML4), 3'b000};
    end else if (!walk_busy) begin
      res.kind = KIND_STRAY;
    end else if (!item.present) begin
      walk_busy_next  = 1'b0;
      walk_level_next = LVL_PML4;
      res.kind        = KIND_DONE;
      res.fault       = 1'b1;
      res.fault_level = walk_level;
    end else if (walk_level == LVL_PD && item.huge) begin
      walk_busy_next  = 1'b0;
      walk_level_next = LVL_PML4;
      res.kind        = KIND_DONE;
      res.huge_page   = 1'b1;
      res.phys_addr   = {item.page[PAGE_BITS-1:HUGE_SHIFT-PAGE_SHIFT],
                         held_vaddr[HUGE_SHIFT-1:0]};
    end else if (walk_level == LVL_PT) begin
      walk_busy_next  = 1'b0;
      walk_level_next = LVL_PML4;
      res.kind        = KIND_DONE;
      res.phys_addr   = {item.page, held_vaddr[PAGE_SHIFT-1:0]};
    end else begin
      walk_level_next = walk_level + 2'd1;
      res.read_addr   = {item.page, level_index(held_vaddr, walk_level + 2'd1), 3'b000};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_base <= '0;
      walk_busy       <= 1'b0;
      walk_level      <= LVL_PML4;
      held_vaddr      <= '0;
    end else begin
      if (cfg_write) begin
        root_table_base <= cfg_data;
      end
      if (step) begin
        walk_busy  <= walk_busy_next;
        walk_level <= walk_level_next;
        held_vaddr <= held_vaddr_next;
      end
    end
  end

endmodule

FILE: rtl/four_level_page_walk.sv
// Page-table walker for four-level x86_64 tables. Push translate requests
// (mode 0) and returned table entries (mode 1); every item yields exactly one
// result: a read request for the next entry, a finished walk (physical
// address, 2 MB flag, or fault with its level), or a stray-data notice. One
// item is taken per cycle while the input queue is not full. An item passes a
// two-entry input queue and the walk stage, and its result is written into a
// two-entry output queue. The walk stage retires one item per cycle and stalls
// only while the output queue is full. A new request aborts any walk in flight.
module four_level_page_walk import fpw_pkg::*; #(
  parameter int PADDR_BITS = 52
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [PA_WIDTH-1:0]    cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic                   mode,
  input  logic [VADDR_BITS-1:0]  virt_addr,
  input  logic [ENTRY_WIDTH-1:0] entry_data,
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             kind,
  output logic [PA_WIDTH-1:0]    read_addr,
  output logic [PA_WIDTH-1:0]    phys_addr,
  output logic                   fault,
  output logic [1:0]             fault_level,
  output logic                   huge_page
);

  item_t   item_in;
  item_t   item_q;
  logic    item_empty;
  logic    step;
  result_t res_in;
  result_t res_q;
  logic    res_full;

  fpw_front #(.PADDR_BITS(PADDR_BITS)) u_front (
    .mode       (mode),
    .virt_addr  (virt_addr),
    .entry_data (entry_data),
    .item       (item_in)
  );

  fpw_fifo #(.WIDTH($bits(item_t)), .DEPTH(2)) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (item_in),
    .full  (full),
    .pop   (step),
    .rdata (item_q),
    .empty (item_empty)
  );

  fpw_back #(.PADDR_BITS(PADDR_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .item_valid (!item_empty),
    .item       (item_q),
    .res_full   (res_full),
    .step       (step),
    .res        (res_in)
  );

  fpw_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (step),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_q),
    .empty (empty)
  );

  assign kind        = res_q.kind;
  assign read_addr   = res_q.read_addr;
  assign phys_addr   = res_q.phys_addr;
  assign fault       = res_q.fault;
  assign fault_level = res_q.fault_level;
  assign huge_page   = res_q.huge_page;

endmodule
